@@ hw/rtl/vkd_pkg.sv @@
// Shared types and constants for the video keyframe detector.
// No dependencies; imported by the top level and by the testbench.
package vkd_pkg;

  // codec_kind register codes
  localparam logic [1:0] CODEC_NONE = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;
  localparam logic [1:0] CODEC_AV1  = 2'd2;

  // default limit on LEB128 size bytes per OBU
  localparam int MAX_SIZE_BYTES_DEF = 8;

  // LEB128 payload bits per size byte
  localparam int LEB_BITS = 7;

  // HEVC NAL types that mark a random-access picture
  localparam logic [5:0] NAL_IRAP_LO = 6'd16;
  localparam logic [5:0] NAL_IRAP_HI = 6'd21;

  // AV1 sequence-header OBU type
  localparam logic [3:0] OBU_SEQ_HDR = 4'h1;

  // start-code marker byte
  localparam logic [7:0] START_BYTE = 8'h01;

  // AV1 OBU walker phase
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_EXT     = 4'b0010,
    PH_SIZE    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } obu_phase_t;

endpackage

@@ hw/rtl/video_keyframe_detector.sv @@
// is_keyframe is valid in the cycle after the accepted last byte of a unit.
// Throughput: one byte per cycle; every byte updates the scan registers in the
// cycle it is accepted, and the output register holds one verdict word.
// A verdict waiting under out_stall blocks input only while it is stalled.
// Reset (rst, synchronous, active high): codec_kind to 0, scan state cleared,
// output empty.
// Depends on vkd_pkg.
module video_keyframe_detector
  import vkd_pkg::*;
#(
  parameter int MAX_SIZE_BYTES = MAX_SIZE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_keyframe
);

  localparam int ACC_W = LEB_BITS * MAX_SIZE_BYTES;
  localparam int IDX_W = (MAX_SIZE_BYTES > 1) ? $clog2(MAX_SIZE_BYTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SIZE_BYTES - 1);

  // configuration and scan registers
  logic [1:0]       codec_kind;
  logic             found_key;
  logic [1:0]       zero_run;
  logic             header_expected;
  obu_phase_t       obu_phase;
  logic [ACC_W-1:0] size_accum;
  logic [IDX_W-1:0] size_byte_index;
  logic [ACC_W-1:0] skip_remaining;
  logic             scan_stopped;

  logic             found_key_next;
  logic [1:0]       zero_run_next;
  logic             header_expected_next;
  obu_phase_t       obu_phase_next;
  logic [ACC_W-1:0] size_accum_next;
  logic [IDX_W-1:0] size_byte_index_next;
  logic [ACC_W-1:0] skip_remaining_next;
  logic             scan_stopped_next;

  logic             accept;
  logic             verdict;
  logic [5:0]       hdr_kind;
  logic [ACC_W-1:0] size_slot;
  logic [ACC_W-1:0] size_merged;

  // input is held off only while a finished verdict is stalled
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign hdr_kind = data_byte[6:1];

  // place the 7 size bits at the slot picked by the byte index
  always_comb begin
    size_slot = '0;
    for (int k = 0; k < MAX_SIZE_BYTES; k++) begin
      if (size_byte_index == IDX_W'(k)) begin
        size_slot[LEB_BITS*k +: LEB_BITS] = data_byte[LEB_BITS-1:0];
      end
    end
  end

  assign size_merged = size_accum | size_slot;

  // next scan state for the current byte
  always_comb begin
    found_key_next       = found_key;
    zero_run_next        = zero_run;
    header_expected_next = header_expected;
    obu_phase_next       = obu_phase;
    size_accum_next      = size_accum;
    size_byte_index_next = size_byte_index;
    skip_remaining_next  = skip_remaining;
    scan_stopped_next    = scan_stopped;

    if (codec_kind == CODEC_HEVC) begin
      // NAL header right after a start code
      if (header_expected) begin
        header_expected_next = 1'b0;
        if (hdr_kind >= NAL_IRAP_LO && hdr_kind <= NAL_IRAP_HI) begin
          found_key_next = 1'b1;
        end
      end
      // zero run and start-code detection
      if (data_byte == 8'h00) begin
        if (zero_run != 2'd2) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        if (data_byte == START_BYTE && zero_run == 2'd2) begin
          header_expected_next = 1'b1;
        end
        zero_run_next = 2'd0;
      end
    end else if (codec_kind == CODEC_AV1 && !scan_stopped) begin
      unique case (obu_phase)
        PH_HEADER: begin
          if (data_byte[6:3] == OBU_SEQ_HDR) begin
            found_key_next    = 1'b1;
            scan_stopped_next = 1'b1;
          end else if (!data_byte[1]) begin
            // no size field: OBU runs to end of unit
            scan_stopped_next = 1'b1;
          end else begin
            size_accum_next      = '0;
            size_byte_index_next = '0;
            obu_phase_next       = data_byte[2] ? PH_EXT : PH_SIZE;
          end
        end
        PH_EXT: begin
          obu_phase_next = PH_SIZE;
        end
        PH_SIZE: begin
          size_accum_next      = size_merged;
          size_byte_index_next = size_byte_index + IDX_W'(1);
          if (!data_byte[7]) begin
            skip_remaining_next = size_merged;
            obu_phase_next      = (size_merged == '0) ? PH_HEADER : PH_PAYLOAD;
          end else if (size_byte_index == IDX_LAST) begin
            // size never terminated
            scan_stopped_next = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          skip_remaining_next = skip_remaining - ACC_W'(1);
          if (skip_remaining == ACC_W'(1)) begin
            obu_phase_next = PH_HEADER;
          end
        end
        default: begin
          obu_phase_next = PH_HEADER;
        end
      endcase
    end
  end

  assign verdict = (codec_kind == CODEC_HEVC || codec_kind == CODEC_AV1) && found_key_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_kind <= CODEC_NONE;
    end else if (cfg_we) begin
      codec_kind <= cfg_wdata;
    end
  end

  // scan registers; cleared after every last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      found_key       <= 1'b0;
      zero_run        <= 2'd0;
      header_expected <= 1'b0;
      obu_phase       <= PH_HEADER;
      size_accum      <= '0;
      size_byte_index <= '0;
      skip_remaining  <= '0;
      scan_stopped    <= 1'b0;
    end else if (accept) begin
      found_key       <= found_key_next;
      zero_run        <= zero_run_next;
      header_expected <= header_expected_next;
      obu_phase       <= obu_phase_next;
      size_accum      <= size_accum_next;
      size_byte_index <= size_byte_index_next;
      skip_remaining  <= skip_remaining_next;
      scan_stopped    <= scan_stopped_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      is_keyframe <= verdict;
    end
  end

endmodule

@@ hw/rtl/vkd_checker.sv @@
// Port-level checks for video_keyframe_detector, attached by bind.
// Depends on the top level's port names.
module vkd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last_byte,
  input logic out_valid,
  input logic out_stall,
  input logic is_keyframe
);

  // a stalled verdict stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_keyframe))
    else $error("verdict changed while stalled");

  // input is only held off by a stalled verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled verdict");

  // every accepted last byte gives a verdict next cycle
  a_last_gives_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no verdict after last byte");

  // a verdict appears only after an accepted last byte
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte))
    else $error("verdict without last byte");

endmodule

bind video_keyframe_detector vkd_checker u_vkd_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for video_keyframe_detector: HEVC start-code and AV1 OBU
// byte streams are checked against a keyframe predictor held in a scoreboard class.
// Depends on vkd_pkg and the detector RTL; reads no files.
module testbench;
  import vkd_pkg::*;

  // reserved codec code, must behave as unsupported
  localparam logic [1:0] CODEC_RSVD = 2'd3;
  // sequence-header OBU byte with size field set, no extension
  localparam logic [7:0] SEQ_HDR_WORD = {1'b0, OBU_SEQ_HDR, 1'b0, 1'b1, 1'b0};
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_WORDS = 680;
  localparam int DRAIN_CYCLES = 4;

  // Keyframe predictor and verdict scoreboard
  class keyframe_checker;
    logic [1:0] codec;
    bit found_key, hdr_pending, scan_stopped;
    int unsigned zero_run, size_idx;
    obu_phase_t phase;
    logic [55:0] size_accum, skip_left;
    logic expected_verdicts[$];
    int unsigned verdicts_checked, keyframes_seen, error_count;

    function new();
      codec = CODEC_NONE;
      verdicts_checked = 0;
      keyframes_seen = 0;
      error_count = 0;
      clear_unit();
    endfunction

    function void clear_unit();
      found_key = 0;
      hdr_pending = 0;
      scan_stopped = 0;
      zero_run = 0;
      size_idx = 0;
      phase = PH_HEADER;
      size_accum = '0;
      skip_left = '0;
    endfunction

    // start-code tracking; the NAL header byte also feeds the zero run
    function void hevc_byte(logic [7:0] b);
      logic [5:0] nal;
      if (hdr_pending) begin
        nal = b[6:1];
        hdr_pending = 0;
        if (nal >= NAL_IRAP_LO && nal <= NAL_IRAP_HI) found_key = 1;
      end
      if (b == 8'h00) begin
        if (zero_run < 2) zero_run++;
      end else begin
        if (b == START_BYTE && zero_run >= 2) hdr_pending = 1;
        zero_run = 0;
      end
    endfunction

    // OBU walk: header, optional extension, LEB128 size, payload skip
    function void av1_byte(logic [7:0] b);
      if (scan_stopped) return;
      case (phase)
        PH_HEADER: begin
          if (b[6:3] == OBU_SEQ_HDR) begin
            found_key = 1;
            scan_stopped = 1;
          end else if (!b[1]) begin
            scan_stopped = 1;
          end else begin
            size_accum = '0;
            size_idx = 0;
            phase = b[2] ? PH_EXT : PH_SIZE;
          end
        end
        PH_EXT: phase = PH_SIZE;
        PH_SIZE: begin
          size_accum |= 56'(b[6:0]) << (LEB_BITS * size_idx);
          size_idx++;
          if (!b[7]) begin
            skip_left = size_accum;
            phase = (skip_left == 0) ? PH_HEADER : PH_PAYLOAD;
          end else if (size_idx >= MAX_SIZE_BYTES_DEF) begin
            scan_stopped = 1;
          end
          size_idx = size_idx & 7;
        end
        default: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) phase = PH_HEADER;
        end
      endcase
    endfunction

    // accepted input word; a last byte queues the unit's verdict
    function void note_byte(logic [7:0] b, logic fin);
      if (codec == CODEC_HEVC) hevc_byte(b);
      else if (codec == CODEC_AV1) av1_byte(b);
      if (fin) begin
        expected_verdicts.push_back((codec == CODEC_HEVC || codec == CODEC_AV1) && found_key);
        clear_unit();
      end
    endfunction

    // accepted result word against the oldest expected verdict
    function void check_verdict(logic got);
      logic want;
      if (expected_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected verdict: expected none, actual %0b", $time, got);
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      if (got !== want) begin
        error_count++;
        $display("%0t: is_keyframe mismatch: expected %0b, actual %0b", $time, want, got);
      end else if (got) begin
        keyframes_seen++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       is_keyframe;

  keyframe_checker tracker;
  logic [7:0] unit_bytes[$];
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  bit long_hold_req = 0;

  video_keyframe_detector u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_keyframe(is_keyframe)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_byte(data_byte, last_byte);
      if (out_valid && !out_stall) tracker.check_verdict(is_keyframe);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: random stall spans, plus a long hold-off on request
  initial begin
    int span;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        span = LONG_HOLD;
      end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
        span = 0;
      end else begin
        span = pick_gap();
      end
      if (span == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  // one input word; called and returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic fin);
    bit taken;
    int gap;
    gap = (tx_quiet || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
    words_sent++;
  endtask

  task automatic send_unit();
    foreach (unit_bytes[i]) send_word(unit_bytes[i], i == unit_bytes.size() - 1);
  endtask

  // codec write once no verdict is outstanding and the pipe has settled
  task automatic write_codec(input logic [1:0] v);
    in_valid <= 1'b0;
    while (tracker.expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    tracker.codec = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Annex-B unit: filler, start codes of varying zero runs, NAL headers, payload
  task automatic build_hevc_unit();
    int nals;
    int t;
    nals = $urandom_range(1, 3);
    for (int n = 0; n < nals; n++) begin
      repeat ($urandom_range(0, 2))
        unit_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : rand_byte());
      repeat ($urandom_range(1, 4)) unit_bytes.push_back(8'h00);
      unit_bytes.push_back(START_BYTE);
      // start code closing the unit
      if (n == nals - 1 && $urandom_range(0, 7) == 0) return;
      t = ($urandom_range(0, 2) == 0) ? $urandom_range(16, 21) : $urandom_range(0, 63);
      unit_bytes.push_back({1'($urandom_range(0, 1)), 6'(t), 1'($urandom_range(0, 1))});
      repeat ($urandom_range(0, 3)) unit_bytes.push_back(rand_byte());
    end
  endtask

  task automatic push_obu_header(input logic [3:0] kind, input bit ext, input bit sized);
    unit_bytes.push_back({1'($urandom_range(0, 1)), kind, ext, sized, 1'($urandom_range(0, 1))});
    if (ext) unit_bytes.push_back(rand_byte());
  endtask

  // LEB128 over a fixed number of bytes; extra bytes are zero padding
  task automatic push_leb(input longint unsigned v, input int width);
    for (int i = 0; i < width; i++)
      unit_bytes.push_back({i != width - 1, 7'(v >> (LEB_BITS * i))});
  endtask

  // OBU stream: mostly well-formed OBUs, some ending in a stop or a truncation
  task automatic build_av1_unit();
    int obus;
    int pick;
    int len;
    int width;
    logic [3:0] kind;
    obus = $urandom_range(1, 3);
    for (int n = 0; n < obus; n++) begin
      pick = $urandom_range(0, 11);
      kind = 4'($urandom_range(0, 14));
      if (kind >= OBU_SEQ_HDR) kind++;
      if (pick < 2) begin
        // sequence header; whatever follows is ignored
        push_obu_header(OBU_SEQ_HDR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) unit_bytes.push_back(rand_byte());
        return;
      end else if (pick == 2) begin
        // no size field: OBU runs to the end, later sequence header unseen
        push_obu_header(kind, 1'($urandom_range(0, 1)), 1'b0);
        repeat ($urandom_range(0, 2)) unit_bytes.push_back(rand_byte());
        if ($urandom_range(0, 1)) unit_bytes.push_back(SEQ_HDR_WORD);
        return;
      end else if (pick == 3) begin
        // size never terminates
        push_obu_header(kind, 1'($urandom_range(0, 1)), 1'b1);
        repeat (MAX_SIZE_BYTES_DEF) unit_bytes.push_back(rand_byte() | 8'h80);
        unit_bytes.push_back(SEQ_HDR_WORD);
        return;
      end else if (pick == 4) begin
        // unit ends inside a random (often huge) size or its payload
        push_obu_header(kind, 1'($urandom_range(0, 1)), 1'b1);
        width = $urandom_range(1, MAX_SIZE_BYTES_DEF);
        for (int i = 0; i < width; i++)
          unit_bytes.push_back((i < width - 1) ? (rand_byte() | 8'h80) : rand_byte());
        repeat ($urandom_range(0, 3)) unit_bytes.push_back(rand_byte());
        return;
      end else begin
        push_obu_header(kind, 1'($urandom_range(0, 1)), 1'b1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 160) : $urandom_range(0, 6);
        width = (len < 128) ? 1 : 2;
        width = $urandom_range(width, ($urandom_range(0, 3) == 0) ? MAX_SIZE_BYTES_DEF : width);
        push_leb(64'(len), width);
        repeat (len) unit_bytes.push_back(rand_byte());
      end
    end
  endtask

  // one unit, mostly in the style of the active codec
  task automatic build_unit(input logic [1:0] codec);
    int r;
    unit_bytes.delete();
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8))
        unit_bytes.push_back(rand_byte());
    end else if (codec == CODEC_HEVC) begin
      if (r == 1) build_av1_unit(); else build_hevc_unit();
    end else if (codec == CODEC_AV1) begin
      if (r == 1) build_hevc_unit(); else build_av1_unit();
    end else begin
      if (r < 5) build_hevc_unit(); else build_av1_unit();
    end
  endtask

  // Directed units: extremes and corner cases
  task automatic run_directed();
    // codec left at reset value: IRAP header still yields no keyframe
    unit_bytes = '{8'h00, 8'h00, 8'h01, 8'h20};
    send_unit();
    write_codec(CODEC_HEVC);
    // 4-byte start code, zero header byte opening the next start code, type 21
    unit_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h2A};
    send_unit();
    // start code with nothing after it
    unit_bytes = '{8'h00, 8'h00, 8'h01};
    send_unit();
    // codec switch inside a unit: HEVC state held, AV1 sees a sequence header
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    write_codec(CODEC_AV1);
    send_word(SEQ_HDR_WORD, 1'b1);
    // extension byte and zero-size OBU before a sequence header
    unit_bytes = '{8'h36, 8'hFF, 8'h00, SEQ_HDR_WORD};
    send_unit();
    // OBU without size field stops the scan
    unit_bytes = '{8'h10, SEQ_HDR_WORD};
    send_unit();
  endtask

  // Random phases over all codec settings
  task automatic run_random();
    logic [1:0] plan[8];
    int target;
    int cut;
    plan = '{CODEC_HEVC, CODEC_AV1, CODEC_NONE, CODEC_HEVC,
             CODEC_RSVD, CODEC_AV1, CODEC_HEVC, CODEC_AV1};
    for (int p = 0; p < 8; p++) begin
      write_codec(plan[p]);
      target = words_sent + RANDOM_WORDS / 8;
      // back-pressure: long receiver hold while the sender streams
      if (p == 1 || p == 6) begin
        tx_quiet = 1;
        long_hold_req = 1;
      end
      while (words_sent < target) begin
        if ($urandom_range(0, 15) == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        build_unit(plan[p]);
        if (unit_bytes.size() > 1 && $urandom_range(0, 24) == 0) begin
          cut = $urandom_range(1, unit_bytes.size() - 1);
          for (int i = 0; i < cut; i++) send_word(unit_bytes[i], 1'b0);
          write_codec(2'($urandom_range(0, 3)));
          for (int i = cut; i < unit_bytes.size(); i++)
            send_word(unit_bytes[i], i == unit_bytes.size() - 1);
          write_codec(plan[p]);
        end else begin
          send_unit();
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    tracker   = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = CODEC_NONE;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();

    // drain outstanding verdicts, then let the pipe settle
    in_valid <= 1'b0;
    while (tracker.expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d bytes in %0d units, %0d of them keyframes", words_sent,
             tracker.verdicts_checked, tracker.keyframes_seen);
    $display("Codecs none, HEVC, AV1 and reserved, with switches inside units");
    if (tracker.error_count == 0 && tracker.expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
